// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rm2rpy_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2rpy_pkg
// Types, constants and helper functions for the ZYX Euler angle extractor.
// ----------------------------------------------------------------------------
package rm2rpy_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int ISQRT_STEPS   = 17;
  localparam int NUM_LANES     = 5;
  localparam int PIPE_DEPTH    = 2 + ISQRT_STEPS + 1 + CORDIC_STAGES;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [18:0] PI_Q16      = 19'sd205887;
  localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;

  // Lane numbers of the CORDIC chains.
  localparam int LANE_PITCH   = 0;
  localparam int LANE_ROLL    = 1;
  localparam int LANE_YAW     = 2;
  localparam int LANE_YAW_POS = 3;
  localparam int LANE_YAW_NEG = 4;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [34:0] z;
    logic               zero;
  } cordic_t;

  typedef struct packed {
    logic [32:0] v;
    logic [33:0] res;
  } isqrt_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [17:0] r00;
    logic signed [17:0] r01;
    logic signed [17:0] r10;
    logic signed [17:0] r11;
    logic signed [17:0] r21;
    logic signed [17:0] r22;
  } front_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               lock;
  } back_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
    logic signed [34:0] a;
    unique case (idx)
      5'd0:  a = 35'sd843314857;
      5'd1:  a = 35'sd497837829;
      5'd2:  a = 35'sd263043837;
      5'd3:  a = 35'sd133525159;
      5'd4:  a = 35'sd67021687;
      5'd5:  a = 35'sd33543516;
      5'd6:  a = 35'sd16775851;
      5'd7:  a = 35'sd8388437;
      5'd8:  a = 35'sd4194283;
      5'd9:  a = 35'sd2097149;
      5'd10: a = 35'sd1048576;
      5'd11: a = 35'sd524288;
      5'd12: a = 35'sd262144;
      5'd13: a = 35'sd131072;
      5'd14: a = 35'sd65536;
      5'd15: a = 35'sd32768;
      5'd16: a = 35'sd16384;
      5'd17: a = 35'sd8192;
      5'd18: a = 35'sd4096;
      5'd19: a = 35'sd2048;
      5'd20: a = 35'sd1024;
      5'd21: a = 35'sd512;
      5'd22: a = 35'sd256;
      5'd23: a = 35'sd128;
      5'd24: a = 35'sd64;
      5'd25: a = 35'sd32;
      5'd26: a = 35'sd16;
      5'd27: a = 35'sd8;
      5'd28: a = 35'sd4;
      5'd29: a = 35'sd2;
      5'd30: a = 35'sd1;
      5'd31: a = 35'sd0;
    endcase
    return a;
  endfunction

  // Scales the operands and folds the left half plane onto the right one.
  function automatic cordic_t cordic_init(input logic signed [18:0] y,
                                          input logic signed [18:0] x);
    cordic_t r;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = 34'(x) <<< 12;
    ys = 34'(y) <<< 12;
    r.zero = (x == 19'sd0) && (y == 19'sd0);
    r.x = xs;
    r.y = ys;
    r.z = 35'sd0;
    if (x < 19'sd0) begin
      r.z = (y >= 19'sd0) ? PI_Q30 : -PI_Q30;
      r.x = -xs;
      r.y = -ys;
    end
    return r;
  endfunction

  // Rounds the Q30 angle to Q16 and saturates it to plus or minus lim.
  function automatic logic signed [18:0] cordic_angle(input cordic_t d,
                                                      input logic signed [18:0] lim);
    logic signed [34:0] t;
    logic signed [18:0] a;
    t = ($signed(d.z) + 35'sd8192) >>> 14;
    if (d.zero) begin
      a = 19'sd0;
    end else if (t > 35'(lim)) begin
      a = lim;
    end else if (t < -35'(lim)) begin
      a = -lim;
    end else begin
      a = 19'(t);
    end
    return a;
  endfunction

endpackage

// ===== hw/rtl/rm2rpy_isqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rm2rpy_isqrt_cell
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module rm2rpy_isqrt_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [32:0]          sq_bit,
  input  rm2rpy_pkg::isqrt_t   d,
  output rm2rpy_pkg::isqrt_t   q
);

  logic [33:0]        sum;
  rm2rpy_pkg::isqrt_t nxt;

  always_comb begin
    sum = d.res + {1'b0, sq_bit};
    nxt = d;
    if ({1'b0, d.v} >= sum) begin
      nxt.v   = 33'({1'b0, d.v} - sum);
      nxt.res = (d.res >> 1) + {1'b0, sq_bit};
    end else begin
      nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hw/rtl/rm2rpy_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rm2rpy_cordic_cell
// One registered vectoring micro-rotation of the CORDIC angle chain.
// ----------------------------------------------------------------------------
module rm2rpy_cordic_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           idx,
  input  rm2rpy_pkg::cordic_t  d,
  output rm2rpy_pkg::cordic_t  q
);

  logic signed [33:0]  dx;
  logic signed [33:0]  dy;
  logic signed [34:0]  ang;
  rm2rpy_pkg::cordic_t nxt;

  always_comb begin
    dx  = $signed(d.y) >>> idx;
    dy  = $signed(d.x) >>> idx;
    ang = rm2rpy_pkg::atan_q30(idx);
    nxt = d;
    // Rotate toward the x axis; the sign of y picks the direction.
    if (!d.y[33]) begin
      nxt.x = $signed(d.x) + dx;
      nxt.y = $signed(d.y) - dy;
      nxt.z = $signed(d.z) + ang;
    end else begin
      nxt.x = $signed(d.x) - dx;
      nxt.y = $signed(d.y) + dy;
      nxt.z = $signed(d.z) - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hw/rtl/rotation_matrix_to_roll_pitch_yaw.sv =====
// Throughput: one transaction per cycle; the whole chain of square root and
// CORDIC cells advances together and holds only while the output is stalled.
// The pipeline depth is set by the front stages, 17 square root cells, the lane setup stage and 18 CORDIC cells.
// Reset (rst, synchronous) empties the pipeline and clears threshold.
// ----------------------------------------------------------------------------
// rotation_matrix_to_roll_pitch_yaw
// ZYX Euler angle extraction from a rotation matrix, position passed through.
// ----------------------------------------------------------------------------
module rotation_matrix_to_roll_pitch_yaw (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] r00,
  input  logic signed [17:0] r01,
  input  logic signed [17:0] r10,
  input  logic signed [17:0] r11,
  input  logic signed [17:0] r20,
  input  logic signed [17:0] r21,
  input  logic signed [17:0] r22,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [18:0] roll,
  output logic signed [17:0] pitch,
  output logic signed [18:0] yaw,
  output logic               gimbal_lock
);

  localparam int CS = rm2rpy_pkg::CORDIC_STAGES;
  localparam int QS = rm2rpy_pkg::ISQRT_STEPS;
  localparam int NL = rm2rpy_pkg::NUM_LANES;
  localparam int PD = rm2rpy_pkg::PIPE_DEPTH;

  logic                 adv;
  logic                 accept;
  logic [PD-1:0]        vpipe;
  logic [16:0]          threshold;

  rm2rpy_pkg::front_t   front0;
  logic signed [17:0]   s0;
  logic signed [18:0]   neg_r20;
  logic signed [17:0]   s_sat;
  logic signed [35:0]   s_sq;
  rm2rpy_pkg::front_t   front_d [QS+1];
  rm2rpy_pkg::isqrt_t   isq     [QS+1];

  logic [16:0]          c_val;
  rm2rpy_pkg::cordic_t  cd      [NL][CS+1];
  rm2rpy_pkg::back_t    back_d  [CS+1];

  logic signed [18:0]   pitch_a;
  logic signed [18:0]   roll_a;
  logic signed [18:0]   yaw_a;
  logic signed [18:0]   yaw_pos_a;
  logic signed [18:0]   yaw_neg_a;

  // The chain moves as one unit whenever the output register can take data.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vpipe     <= {vpipe[PD-2:0], accept};
      out_valid <= vpipe[PD-1];
    end
  end

  always_comb begin
    neg_r20 = -19'(r20);
    if (neg_r20 > 19'sd65536) begin
      s_sat = 18'sd65536;
    end else if (neg_r20 < -19'sd65536) begin
      s_sat = -18'sd65536;
    end else begin
      s_sat = 18'(neg_r20);
    end
  end

  assign s_sq = s0 * s0;

  // Stage 0 saturates sin(pitch); stage 1 forms 1 - sin^2 for the root.
  always_ff @(posedge clk) begin
    if (adv) begin
      front0     <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z, r00: r00, r01: r01,
                      r10: r10, r11: r11, r21: r21, r22: r22};
      s0         <= s_sat;
      front_d[0] <= front0;
      isq[0].v   <= 33'(36'sd4294967296 - s_sq);
      isq[0].res <= '0;
    end
  end

  for (genvar k = 0; k < QS; k++) begin : g_isqrt
    rm2rpy_isqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .sq_bit (33'(1) << (32 - 2 * k)),
      .d      (isq[k]),
      .q      (isq[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        front_d[k+1] <= front_d[k];
      end
    end
  end

  assign c_val = isq[QS].res[16:0];

  // Set up the five angle lanes; the sin(pitch) value rides along in front.
  logic signed [17:0] s_d [QS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      s_d[0] <= s0;
    end
  end
  for (genvar k = 0; k < QS; k++) begin : g_sdelay
    always_ff @(posedge clk) begin
      if (adv) begin
        s_d[k+1] <= s_d[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd[rm2rpy_pkg::LANE_PITCH][0]   <= rm2rpy_pkg::cordic_init(19'(s_d[QS]),
                                                                 $signed({2'b00, c_val}));
      cd[rm2rpy_pkg::LANE_ROLL][0]    <= rm2rpy_pkg::cordic_init(19'(front_d[QS].r21),
                                                                 19'(front_d[QS].r22));
      cd[rm2rpy_pkg::LANE_YAW][0]     <= rm2rpy_pkg::cordic_init(19'(front_d[QS].r10),
                                                                 19'(front_d[QS].r00));
      cd[rm2rpy_pkg::LANE_YAW_POS][0] <= rm2rpy_pkg::cordic_init(19'(front_d[QS].r01),
                                                                 19'(front_d[QS].r11));
      cd[rm2rpy_pkg::LANE_YAW_NEG][0] <= rm2rpy_pkg::cordic_init(-19'(front_d[QS].r01),
                                                                 19'(front_d[QS].r11));
      back_d[0].pos_x <= front_d[QS].pos_x;
      back_d[0].pos_y <= front_d[QS].pos_y;
      back_d[0].pos_z <= front_d[QS].pos_z;
      back_d[0].lock  <= !(c_val > threshold);
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    for (genvar k = 0; k < CS; k++) begin : g_stage
      rm2rpy_cordic_cell u_cell (
        .clk (clk),
        .en  (adv),
        .idx (5'(k)),
        .d   (cd[l][k]),
        .q   (cd[l][k+1])
      );
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_back
    always_ff @(posedge clk) begin
      if (adv) begin
        back_d[k+1] <= back_d[k];
      end
    end
  end

  always_comb begin
    pitch_a   = rm2rpy_pkg::cordic_angle(cd[rm2rpy_pkg::LANE_PITCH][CS],
                                         rm2rpy_pkg::HALF_PI_Q16);
    roll_a    = rm2rpy_pkg::cordic_angle(cd[rm2rpy_pkg::LANE_ROLL][CS],
                                         rm2rpy_pkg::PI_Q16);
    yaw_a     = rm2rpy_pkg::cordic_angle(cd[rm2rpy_pkg::LANE_YAW][CS],
                                         rm2rpy_pkg::PI_Q16);
    yaw_pos_a = rm2rpy_pkg::cordic_angle(cd[rm2rpy_pkg::LANE_YAW_POS][CS],
                                         rm2rpy_pkg::PI_Q16);
    yaw_neg_a = rm2rpy_pkg::cordic_angle(cd[rm2rpy_pkg::LANE_YAW_NEG][CS],
                                         rm2rpy_pkg::PI_Q16);
  end

  // In gimbal lock the yaw lane is picked by the sign of the final pitch.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x       <= back_d[CS].pos_x;
      out_y       <= back_d[CS].pos_y;
      out_z       <= back_d[CS].pos_z;
      pitch       <= 18'(pitch_a);
      gimbal_lock <= back_d[CS].lock;
      if (back_d[CS].lock) begin
        roll <= '0;
        yaw  <= pitch_a[18] ? yaw_neg_a : yaw_pos_a;
      end else begin
        roll <= roll_a;
        yaw  <= yaw_a;
      end
    end
  end

endmodule

// ===== hw/rtl/rm2rpy_checker.sv =====
// ----------------------------------------------------------------------------
// rm2rpy_checker
// Port-level assertions for the Euler angle extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rm2rpy_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [18:0] roll,
  input logic signed [17:0] pitch,
  input logic               gimbal_lock
);

  // A stalled result transaction stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // The input side only waits behind a stalled result.
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  `ASSERT_IMPLIES(a_lock_roll, clk, rst, out_valid && gimbal_lock, roll == 19'sd0)

  `ASSERT_IMPLIES(a_pitch_range, clk, rst, out_valid,
                  (pitch <= 18'sd102944) && (pitch >= -18'sd102944))

endmodule

bind rotation_matrix_to_roll_pitch_yaw rm2rpy_checker u_rm2rpy_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ZYX Euler extractor. A behavioral predictor
// computes pitch, roll, yaw and the gimbal lock flag for each pose, and a
// scoreboard compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int STAGES = 18;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint PI16 = 205887;
  localparam longint HPI16 = 102944;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [18:0] roll;
    logic signed [17:0] pitch;
    logic signed [18:0] yaw;
    logic               lock;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [17:0] r00 = '0, r01 = '0, r10 = '0, r11 = '0;
  logic signed [17:0] r20 = '0, r21 = '0, r22 = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic signed [18:0] roll, yaw;
  logic signed [17:0] pitch;
  logic gimbal_lock;

  angles_t pending_angles[$];
  logic [16:0] threshold = '0;
  int errors = 0;
  int results_seen = 0;
  int lock_seen = 0;
  int in_idle_pct = 26;
  int out_idle_pct = 26;
  int hold_cycles = 0;

  rotation_matrix_to_roll_pitch_yaw dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .r00(r00), .r01(r01), .r10(r10), .r11(r11), .r20(r20), .r21(r21), .r22(r22),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .roll(roll), .pitch(pitch), .yaw(yaw), .gimbal_lock(gimbal_lock)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint lim(longint v, longint m);
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[18] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint yi, longint xi);
    longint xv, yv, zv, dx, dy;
    if (xi == 0 && yi == 0) return 0;
    xv = xi * 4096;
    yv = yi * 4096;
    zv = 0;
    if (xv < 0) begin
      zv = (yv >= 0) ? PI30 : -PI30;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = fshr(yv, i);
      dy = fshr(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; zv += atan_step(i);
      end else begin
        xv -= dx; yv += dy; zv -= atan_step(i);
      end
    end
    return fshr(zv + 8192, 14);
  endfunction

  function automatic longint root_floor(longint v);
    longint rt;
    rt = 0;
    for (int b = 16; b >= 0; b--)
      if ((rt + (64'sd1 << b)) * (rt + (64'sd1 << b)) <= v) rt += 64'sd1 << b;
    return rt;
  endfunction

  function automatic angles_t predict_angles(longint a00, a01, a10, a11, a20, a21,
                                             a22, logic [31:0] px, py, pz);
    angles_t e;
    longint s, c, p, rl, yw;
    logic lk;
    s = lim(-a20, 65536);
    c = root_floor(64'sd4294967296 - s * s);
    p = lim(vector_angle(s, c), HPI16);
    lk = !(c > longint'(threshold));
    if (!lk) begin
      rl = lim(vector_angle(a21, a22), PI16);
      yw = lim(vector_angle(a10, a00), PI16);
    end else begin
      rl = 0;
      yw = lim(vector_angle(p < 0 ? -a01 : a01, a11), PI16);
    end
    e.x = px; e.y = py; e.z = pz;
    e.roll = rl[18:0]; e.pitch = p[17:0]; e.yaw = yw[18:0]; e.lock = lk;
    return e;
  endfunction

  // Leaves in_valid high after the accepting edge; the next call either
  // replaces the payload or drops valid, so each edge sees one update.
  task automatic send_pose(logic signed [17:0] a00, a01, a10, a11, a20, a21, a22,
                           logic [31:0] px, py, pz);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r00 <= a00; r01 <= a01; r10 <= a10; r11 <= a11;
    r20 <= a20; r21 <= a21; r22 <= a22;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    in_valid <= 1'b1;
    pending_angles.push_back(predict_angles(a00, a01, a10, a11, a20, a21, a22,
                                            px, py, pz));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random element: mostly within one, sometimes over the full Q2.16 range.
  function automatic logic signed [17:0] rand_elem();
    case ($urandom_range(9))
      0: return 18'($urandom);
      1: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
      2: return 18'($signed($urandom_range(8)) - 4);
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic send_random_pose();
    logic signed [17:0] a20;
    case ($urandom_range(5))
      0: a20 = $urandom_range(1) ? 18'sd65536 - 18'($urandom_range(40))
                                 : -18'sd65536 + 18'($urandom_range(40));
      default: a20 = rand_elem();
    endcase
    send_pose(rand_elem(), rand_elem(), rand_elem(), rand_elem(), a20, rand_elem(),
              rand_elem(), $urandom, $urandom, $urandom);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_threshold(logic [16:0] v);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    threshold = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_poses();
    send_pose(18'sd65536, 0, 0, 18'sd65536, 0, 0, 18'sd65536, 0, 0, 0);
    send_pose(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_pose(-18'sd65536, 0, 0, -18'sd65536, 0, 0, -18'sd65536, 1, 2, 3);
    send_pose(18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071,
              18'sd131071, 18'sd131071, 32'h55555555, 32'haaaaaaaa, 0);
    send_pose(-18'sd131072, -18'sd131072, -18'sd131072, -18'sd131072, -18'sd131072,
              -18'sd131072, -18'sd131072, 32'haaaaaaaa, 32'h55555555, 1);
    // Pitch at plus and minus a quarter turn hits gimbal lock with both signs.
    send_pose(0, 18'sd46341, 0, 18'sd46341, -18'sd65536, 5, 7, 4, 5, 6);
    send_pose(0, 18'sd46341, 0, 18'sd46341, 18'sd65536, 5, 7, 4, 5, 6);
    send_pose(0, -18'sd46341, 0, -18'sd46341, 18'sd65536, 0, 0, 7, 8, 9);
    send_pose(18'sd46341, 0, -18'sd46341, 0, 0, -18'sd46341, 18'sd46341, 0, 0, 0);
    send_pose(0, 0, -18'sd1, -18'sd1, 18'sd37000, 0, -18'sd1, 0, 0, 0);
    send_pose(-18'sd1, 0, 0, 0, -18'sd37000, 18'sd1, -18'sd1, 0, 0, 0);
  endtask

  task automatic test_threshold_settings();
    logic [16:0] tv[5] = '{17'd65536, 17'd0, 17'd1000, 17'd65535, 17'd32768};
    foreach (tv[k]) begin
      write_threshold(tv[k]);
      send_pose(0, 18'sd100, 0, 18'sd200, 18'sd65535, 1, 1, k, k, k);
      repeat (40) send_random_pose();
    end
  endtask

  task automatic test_random_poses();
    for (int n = 0; n < 1700; n++) begin
      if (n == 300) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (n == 600) begin
        in_idle_pct = 26;
        out_idle_pct = 26;
      end
      if (n == 900) hold_cycles = 150;
      if (n % 400 == 399) write_threshold(17'($urandom_range(65536)));
      send_random_pose();
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= out_idle_pct > 0 && $urandom_range(99) < out_idle_pct;
    end
  end

  always @(posedge clk) begin
    angles_t e, a;
    if (!rst && out_valid && !out_stall) begin
      a = '{out_x, out_y, out_z, roll, pitch, yaw, gimbal_lock};
      results_seen++;
      if (gimbal_lock) lock_seen++;
      if (pending_angles.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, a);
      end else begin
        e = pending_angles.pop_front();
        if (e.x != a.x) begin
          errors++; $display("%0t: out_x exp %h got %h", $time, e.x, a.x);
        end
        if (e.y != a.y) begin
          errors++; $display("%0t: out_y exp %h got %h", $time, e.y, a.y);
        end
        if (e.z != a.z) begin
          errors++; $display("%0t: out_z exp %h got %h", $time, e.z, a.z);
        end
        if (e.roll != a.roll) begin
          errors++; $display("%0t: roll exp %0d got %0d", $time, e.roll, a.roll);
        end
        if (e.pitch != a.pitch) begin
          errors++; $display("%0t: pitch exp %0d got %0d", $time, e.pitch, a.pitch);
        end
        if (e.yaw != a.yaw) begin
          errors++; $display("%0t: yaw exp %0d got %0d", $time, e.yaw, a.yaw);
        end
        if (e.lock != a.lock) begin
          errors++; $display("%0t: lock exp %0d got %0d", $time, e.lock, a.lock);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_poses();
    test_threshold_settings();
    test_random_poses();
    drain_pipeline();
    $display("Checked %0d poses, %0d in gimbal lock, across several thresholds",
             results_seen, lock_seen);
    $display("including a long output hold-off and back-to-back streaming.");
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
